// File: hdl/prs_pkg.sv
package prs_pkg;

    localparam int unsigned MaxLengthDefault = 4096;

    localparam int unsigned CountW   = 16;
    localparam int unsigned GapW     = 12;
    localparam int unsigned CoordW   = 12;
    localparam int unsigned ThickW   = 13;
    localparam int unsigned CfgIdxW  = 1;
    localparam int unsigned CfgDataW = 16;

    // result queue: room for two beats from one item plus slack
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    typedef enum logic [CfgIdxW-1:0] {
        REG_COUNT_THRESHOLD = 1'b0,
        REG_JOIN_SPAN       = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CountW-1:0] profile_count;
        logic              last_position;
    } prof_item_t;

    typedef struct packed {
        logic [CoordW-1:0] seg_start;
        logic [CoordW-1:0] seg_end;
        logic [ThickW-1:0] seg_thickness;
        logic              seg_valid;
        logic              seg_last;
    } seg_item_t;

    // up to two result beats per profile position, oldest in first
    typedef struct packed {
        logic [1:0] count;
        seg_item_t  first;
        seg_item_t  second;
    } seg_push_t;

endpackage

// File: hdl/profile_run_segmenter_core.sv
// Flow: an accepted beat waits in the input stage until the queue has two free
//   slots (input stalls when < 2 free), then is processed and its beats queued.
// Throughput: one profile position per cycle while the queue has room; each gives
//   0 to 2 result beats, drained one per cycle while out_ready through a 4-entry queue.
// Reset (rst_n, async, active low): clears position/run/pending state, queue,
//   input stage and both config registers (threshold 0, merge gap 0).
module profile_run_segmenter_core #(
    parameter int unsigned MAX_LENGTH = prs_pkg::MaxLengthDefault
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // profile positions
    input  logic                            in_valid,
    output logic                            in_ready,
    input  prs_pkg::prof_item_t             in_data,
    // segments
    output logic                            out_valid,
    input  logic                            out_ready,
    output prs_pkg::seg_item_t              out_data,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prs_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [prs_pkg::CfgDataW-1:0]    cfg_data
);

    // config registers
    logic [prs_pkg::CountW-1:0] threshold_reg, threshold_next;
    logic [prs_pkg::GapW-1:0]   join_span_reg, join_span_next;

    // input stage: one position waiting for queue room
    logic                 stage_valid_reg, stage_valid_next;
    prs_pkg::prof_item_t  stage_item_reg;
    logic                 step;
    logic                 room;
    prs_pkg::seg_push_t   push;

    // config writes are always taken; block is idle by contract
    assign cfg_ready = 1'b1;

    always_comb
    begin
        threshold_next = threshold_reg;
        join_span_next = join_span_reg;
        if (cfg_valid)
        begin
            unique case (prs_pkg::cfg_reg_t'(cfg_index))
                prs_pkg::REG_COUNT_THRESHOLD: threshold_next = cfg_data;
                prs_pkg::REG_JOIN_SPAN:       join_span_next = cfg_data[prs_pkg::GapW-1:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            join_span_reg <= '0;
        end
        else
        begin
            threshold_reg <= threshold_next;
            join_span_reg <= join_span_next;
        end
    end

    // the staged position is processed once the queue can hold two beats
    assign step     = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || step;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_valid && in_ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (step)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= in_data;
        end
    end

    // run tracking, merge decision and result formatting
    prs_seg #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_seg (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .item            (stage_item_reg),
        .count_threshold (threshold_reg),
        .join_span       (join_span_reg),
        .push            (push)
    );

    // result register file; head entry drives the output port
    prs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: hdl/prs_seg.sv
module prs_seg #(
    parameter int unsigned MAX_LENGTH = prs_pkg::MaxLengthDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  prs_pkg::prof_item_t           item,
    input  logic [prs_pkg::CountW-1:0]    count_threshold,
    input  logic [prs_pkg::GapW-1:0]      join_span,
    output prs_pkg::seg_push_t            push
);

    localparam int unsigned PosW  = $clog2(MAX_LENGTH);
    localparam int unsigned DiffW = (PosW > prs_pkg::GapW) ? PosW : prs_pkg::GapW;
    localparam int unsigned ExtW  = (PosW > prs_pkg::ThickW) ? PosW : prs_pkg::ThickW;
    localparam logic [PosW-1:0] LastPos = PosW'(MAX_LENGTH - 1);

    logic [PosW-1:0] position_reg, position_next;
    logic            in_run_reg, in_run_next;
    logic [PosW-1:0] run_begin_reg, run_begin_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [PosW-1:0] pend_begin_reg, pend_begin_next;
    logic [PosW-1:0] pend_finish_reg, pend_finish_next;

    logic            active;
    logic            last;
    logic            finish;
    logic [PosW-1:0] fin_begin;
    logic [PosW-1:0] fin_end;
    logic [PosW-1:0] gap_diff;
    logic            join_run;
    logic            emit_old;
    logic            post_valid;
    logic [PosW-1:0] post_begin;
    logic [PosW-1:0] post_finish;
    prs_pkg::seg_item_t old_seg;
    prs_pkg::seg_item_t final_seg;

    // positions reported modulo 4096, thickness modulo 8192
    function automatic prs_pkg::seg_item_t make_seg(
        input logic [PosW-1:0] b,
        input logic [PosW-1:0] e,
        input logic            is_last
    );
        logic [ExtW-1:0]    be;
        logic [ExtW-1:0]    ee;
        logic [ExtW-1:0]    th;
        prs_pkg::seg_item_t r;
        be = ExtW'(b);
        ee = ExtW'(e);
        th = ee - be + ExtW'(1);
        r.seg_start     = be[prs_pkg::CoordW-1:0];
        r.seg_end       = ee[prs_pkg::CoordW-1:0];
        r.seg_thickness = th[prs_pkg::ThickW-1:0];
        r.seg_valid     = 1'b1;
        r.seg_last      = is_last;
        return r;
    endfunction

    always_comb
    begin
        active = item.profile_count > count_threshold;
        last   = item.last_position || (position_reg == LastPos);
        finish = (active && last) || (!active && in_run_reg);

        fin_begin = (active && !in_run_reg) ? position_reg : run_begin_reg;
        fin_end   = active ? position_reg : position_reg - PosW'(1);

        // runs never overlap, so the distance is never negative
        gap_diff = fin_begin - pend_finish_reg;
        join_run = pend_valid_reg && (DiffW'(gap_diff) <= DiffW'(join_span));
        emit_old = finish && pend_valid_reg && !join_run;

        post_valid  = pend_valid_reg || finish;
        post_begin  = (finish && !join_run) ? fin_begin : pend_begin_reg;
        post_finish = finish ? fin_end : pend_finish_reg;

        old_seg = make_seg(pend_begin_reg, pend_finish_reg, 1'b0);
        if (post_valid)
        begin
            final_seg = make_seg(post_begin, post_finish, 1'b1);
        end
        else
        begin
            final_seg          = '0;
            final_seg.seg_last = 1'b1;
        end
    end

    always_comb
    begin
        push.count  = step ? {emit_old && last, emit_old ^ last} : 2'd0;
        push.first  = emit_old ? old_seg : final_seg;
        push.second = final_seg;
    end

    always_comb
    begin
        position_next    = position_reg;
        in_run_next      = in_run_reg;
        run_begin_next   = run_begin_reg;
        pend_valid_next  = pend_valid_reg;
        pend_begin_next  = pend_begin_reg;
        pend_finish_next = pend_finish_reg;
        if (step)
        begin
            if (last)
            begin
                position_next    = '0;
                in_run_next      = 1'b0;
                run_begin_next   = '0;
                pend_valid_next  = 1'b0;
                pend_begin_next  = '0;
                pend_finish_next = '0;
            end
            else
            begin
                position_next    = position_reg + PosW'(1);
                in_run_next      = active;
                run_begin_next   = fin_begin;
                pend_valid_next  = post_valid;
                pend_begin_next  = post_begin;
                pend_finish_next = post_finish;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            in_run_reg      <= 1'b0;
            run_begin_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            pend_begin_reg  <= '0;
            pend_finish_reg <= '0;
        end
        else
        begin
            position_reg    <= position_next;
            in_run_reg      <= in_run_next;
            run_begin_reg   <= run_begin_next;
            pend_valid_reg  <= pend_valid_next;
            pend_begin_reg  <= pend_begin_next;
            pend_finish_reg <= pend_finish_next;
        end
    end

endmodule

// File: hdl/prs_queue.sv
module prs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  prs_pkg::seg_push_t  push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output prs_pkg::seg_item_t  out_data
);

    prs_pkg::seg_item_t                 mem_reg [prs_pkg::QueueDepth];
    logic [prs_pkg::QueuePtrW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [prs_pkg::QueuePtrW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [prs_pkg::QueueCntW-1:0]      cnt_reg, cnt_next;
    logic [prs_pkg::QueuePtrW-1:0]      wr_ptr_inc;
    logic                               pop;

    assign out_valid  = (cnt_reg != '0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    // two free slots: an item may push two beats
    assign room       = (cnt_reg <= prs_pkg::QueueCntW'(prs_pkg::QueueDepth - 2));
    assign wr_ptr_inc = wr_ptr_reg + prs_pkg::QueuePtrW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + prs_pkg::QueuePtrW'(push.count);
        rd_ptr_next = rd_ptr_reg + prs_pkg::QueuePtrW'(pop);
        cnt_next    = cnt_reg + prs_pkg::QueueCntW'(push.count)
                      - prs_pkg::QueueCntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hdl/prs_checker.sv
module prs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input prs_pkg::seg_item_t              out_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // empty marker is all zero and closes the profile
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.seg_valid |->
            out_data.seg_last && out_data.seg_thickness == '0
            && out_data.seg_start == '0 && out_data.seg_end == '0)
        else $error("malformed empty marker");

    // thickness agrees with start and end in the reported low bits
    a_thick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.seg_valid |->
            (out_data.seg_end - out_data.seg_start + 12'd1)
                == out_data.seg_thickness[11:0])
        else $error("thickness inconsistent with bounds");

    // nothing comes out in the first cycle after reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result beat right after reset");

endmodule

bind profile_run_segmenter_core prs_checker u_prs_checker (.*);
